// ===== hdl/plt_pkg.sv =====
// Shared types and codes for the playback lifecycle tracker.
// Used by plt_step and playback_lifecycle_tracker; no dependencies.
package plt_pkg;

  localparam int unsigned TagW   = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned CycW   = 16;

  localparam logic signed [31:0] KIND_NONE = -32'sd1;

  typedef enum logic [3:0] {
    ACT_BEGIN_PREPARE = 4'd0,
    ACT_COMMIT        = 4'd1,
    ACT_FRAME         = 4'd2,
    ACT_PREP_FAIL     = 4'd3,
    ACT_FAIL_VISIBLE  = 4'd4,
    ACT_PROGRESS      = 4'd5,
    ACT_WSTART        = 4'd6,
    ACT_WSTOP         = 4'd7,
    ACT_WEXIT         = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PREP = 3'd1,
    PH_PLAY = 3'd2,
    PH_DONE = 3'd3,
    PH_FAIL = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PREPARING = 3'd1,
    EV_COMMITTED = 3'd2,
    EV_CYCLE     = 3'd3,
    EV_COMPLETED = 3'd4,
    EV_FAILED    = 3'd5
  } ev_kind_t;

  typedef struct packed {
    action_t            action;
    logic [TagW-1:0]    generation;
    logic [TagW-1:0]    ticket;
    logic signed [31:0] clip_kind;
    logic [31:0]        frame_number;
    logic [31:0]        frame_total;
    logic               looping;
    logic [3:0]         failure_code;
  } item_t;

  typedef struct packed {
    phase_t             phase;
    logic [TagW-1:0]    prep_generation;
    logic [TagW-1:0]    prep_ticket;
    logic signed [31:0] prep_kind;
    logic [TagW-1:0]    shown_generation;
    logic [TagW-1:0]    shown_ticket;
    logic signed [31:0] shown_kind;
    logic [CountW-1:0]  prep_fail_count;
    logic [31:0]        cycle_count;
    logic               terminal_sent;
    logic [31:0]        event_counter;
    logic               worker_on;
    logic               stop_requested;
  } state_t;

  typedef struct packed {
    ev_kind_t           event_kind;
    logic [3:0]         event_failure;
    logic [TagW-1:0]    event_generation;
    logic [TagW-1:0]    event_ticket;
    logic signed [31:0] event_clip_kind;
    logic [CycW-1:0]    cycles_done;
    logic [31:0]        sequence_number;
    phase_t             phase_now;
    logic               retry_allowed;
    logic               worker_active;
    logic               stop_pending;
    logic               last;
  } result_t;

endpackage

// ===== hdl/playback_lifecycle_tracker.sv =====
// A word accepted into the input register is evaluated there by plt_step; its result
// words are loaded into the two-entry result buffer and offered from its head.
// One input word per cycle while the output takes each result word as offered; a
// commit that yields two results holds the input side while the result buffer drains.
// Reset (rst, synchronous): phase idle, tags cleared, kinds none, counters and
// worker flags zero, failure limit zero, both buffers empty.
module playback_lifecycle_tracker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data,      // prepare_failure_limit
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // generation[31:0], ticket[63:32], clip_kind[95:64], frame_number[127:96],
  // frame_total[159:128], looping[160], failure_code[164:161], zero pad
  input  logic [167:0] s_axis_tdata,
  input  logic [3:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // event_failure[3:0], event_generation[35:4], event_ticket[67:36],
  // event_clip_kind[99:68], cycles_done[115:100], sequence_number[147:116],
  // phase_now[150:148], retry_allowed[151], worker_active[152],
  // stop_pending[153], zero pad
  output logic [159:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,  // event_kind
  output logic         m_axis_tlast
);
  import plt_pkg::*;

  logic       [7:0] limit;
  state_t           state;
  state_t           state_next;
  item_t            in_item;
  logic             in_valid;
  result_t          slot0;
  result_t          slot1;
  logic       [1:0] count;
  result_t          res0;
  result_t          res1;
  logic             two;
  logic             m_fire;
  logic             can_load;
  logic             step_fire;

  assign cfg_ready     = 1'b1;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign can_load      = (count == 2'd0) || ((count == 2'd1) && m_fire);
  assign step_fire     = in_valid && can_load;
  assign s_axis_tready = !in_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.action       <= action_t'(s_axis_tuser);
      in_item.generation   <= s_axis_tdata[31:0];
      in_item.ticket       <= s_axis_tdata[63:32];
      in_item.clip_kind    <= s_axis_tdata[95:64];
      in_item.frame_number <= s_axis_tdata[127:96];
      in_item.frame_total  <= s_axis_tdata[159:128];
      in_item.looping      <= s_axis_tdata[160];
      in_item.failure_code <= s_axis_tdata[164:161];
    end
  end

  plt_step u_step (
    .cur   (state),
    .item  (in_item),
    .limit (limit),
    .nxt   (state_next),
    .res0  (res0),
    .res1  (res1),
    .two   (two)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase            <= PH_IDLE;
      state.prep_generation  <= '0;
      state.prep_ticket      <= '0;
      state.prep_kind        <= KIND_NONE;
      state.shown_generation <= '0;
      state.shown_ticket     <= '0;
      state.shown_kind       <= KIND_NONE;
      state.prep_fail_count  <= '0;
      state.cycle_count      <= '0;
      state.terminal_sent    <= 1'b0;
      state.event_counter    <= '0;
      state.worker_on        <= 1'b0;
      state.stop_requested   <= 1'b0;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // two-entry result buffer, slot0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (step_fire) begin
      count <= two ? 2'd2 : 2'd1;
    end else if (m_fire) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (m_fire) begin
      slot0 <= slot1;
    end
  end

  assign m_axis_tvalid = count != 2'd0;
  assign m_axis_tuser  = slot0.event_kind;
  assign m_axis_tlast  = slot0.last;
  assign m_axis_tdata  = {6'd0, slot0.stop_pending, slot0.worker_active, slot0.retry_allowed,
                          slot0.phase_now, slot0.sequence_number, slot0.cycles_done,
                          slot0.event_clip_kind, slot0.event_ticket, slot0.event_generation,
                          slot0.event_failure};

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");

  a_pair_loaded: assert property (@(posedge clk) disable iff (rst)
    step_fire && two |=> count == 2'd2 && !m_axis_tlast)
    else $error("two-result word not buffered as a pair");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == EV_NONE) |-> m_axis_tlast)
    else $error("status word not marked last");

  a_seq_count: assert property (@(posedge clk) disable iff (rst)
    step_fire |=> state.event_counter ==
      $past(state.event_counter) + ($past(two) ? 32'd2 :
      (($past(res0.event_kind) != EV_NONE) ? 32'd1 : 32'd0)))
    else $error("event counter does not match emitted events");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !can_load |=> in_valid && $stable(in_item))
    else $error("held input word lost");

endmodule

// ===== hdl/plt_step.sv =====
// Next-state and result logic for one event word of the lifecycle tracker.
// Purely combinational; depends on plt_pkg.
module plt_step (
  input  plt_pkg::state_t  cur,
  input  plt_pkg::item_t   item,
  input  logic [7:0]       limit,
  output plt_pkg::state_t  nxt,
  output plt_pkg::result_t res0,
  output plt_pkg::result_t res1,
  output logic             two
);
  import plt_pkg::*;

  logic               prep_match;
  logic               shown_match;
  logic               at_end;
  logic [CountW-1:0]  fail_cnt_sat;
  logic [31:0]        cyc_inc;
  logic [1:0]         n_ev;
  ev_kind_t           k0;
  ev_kind_t           k1;
  logic [3:0]         f0;
  logic signed [31:0] c0;
  logic [CycW-1:0]    cd0;
  logic [CycW-1:0]    cd1;
  logic               retry;

  assign prep_match   = (cur.phase == PH_PREP) && (cur.prep_generation == item.generation) &&
                        (cur.prep_ticket == item.ticket);
  assign shown_match  = (cur.shown_generation == item.generation) &&
                        (cur.shown_ticket == item.ticket);
  assign at_end       = item.frame_number == (item.frame_total - 32'd1);
  assign fail_cnt_sat = (cur.prep_fail_count == {CountW{1'b1}}) ? cur.prep_fail_count
                                                               : cur.prep_fail_count + 8'd1;
  assign cyc_inc      = cur.cycle_count + 32'd1;

  always_comb begin
    nxt  = cur;
    n_ev = 2'd0;
    k0   = EV_NONE;
    k1   = EV_NONE;
    f0   = 4'd0;
    c0   = item.clip_kind;
    cd0  = cur.cycle_count[CycW-1:0];
    cd1  = '0;
    unique case (item.action)
      ACT_BEGIN_PREPARE: begin
        if (item.generation != '0) begin
          nxt.phase           = PH_PREP;
          nxt.prep_generation = item.generation;
          nxt.prep_ticket     = item.ticket;
          nxt.prep_kind       = item.clip_kind;
          nxt.prep_fail_count = '0;
          nxt.terminal_sent   = 1'b0;
          n_ev                = 2'd1;
          k0                  = EV_PREPARING;
        end
      end
      ACT_COMMIT: begin
        if (prep_match && (cur.prep_kind == item.clip_kind) && (item.frame_total != '0)) begin
          nxt.shown_generation = item.generation;
          nxt.shown_ticket     = item.ticket;
          nxt.shown_kind       = item.clip_kind;
          nxt.prep_generation  = '0;
          nxt.prep_ticket      = '0;
          nxt.prep_kind        = KIND_NONE;
          nxt.prep_fail_count  = '0;
          nxt.cycle_count      = '0;
          nxt.phase            = PH_PLAY;
          n_ev                 = 2'd1;
          k0                   = EV_COMMITTED;
          cd0                  = '0;
          // single-frame clip finishes (or wraps) on the commit itself
          if (item.frame_total == 32'd1) begin
            n_ev = 2'd2;
            if (item.looping) begin
              nxt.cycle_count = 32'd1;
              k1              = EV_CYCLE;
              cd1             = 16'd1;
            end else begin
              nxt.phase         = PH_DONE;
              nxt.terminal_sent = 1'b1;
              k1                = EV_COMPLETED;
            end
          end
        end
      end
      ACT_FRAME: begin
        if (shown_match && (item.frame_total != '0) &&
            ((cur.phase == PH_PLAY) || (cur.phase == PH_DONE))) begin
          c0 = cur.shown_kind;
          if (item.looping && at_end) begin
            nxt.cycle_count = cyc_inc;
            n_ev            = 2'd1;
            k0              = EV_CYCLE;
            cd0             = cyc_inc[CycW-1:0];
          end else if (!item.looping && at_end && !cur.terminal_sent) begin
            nxt.phase         = PH_DONE;
            nxt.terminal_sent = 1'b1;
            n_ev              = 2'd1;
            k0                = EV_COMPLETED;
          end
        end
      end
      ACT_PREP_FAIL: begin
        if (prep_match && !cur.terminal_sent) begin
          nxt.prep_fail_count = fail_cnt_sat;
          if ((limit == '0) || (fail_cnt_sat >= limit)) begin
            nxt.phase           = PH_FAIL;
            nxt.prep_generation = '0;
            nxt.prep_ticket     = '0;
            nxt.prep_kind       = KIND_NONE;
            nxt.terminal_sent   = 1'b1;
            n_ev                = 2'd1;
            k0                  = EV_FAILED;
            f0                  = item.failure_code;
            c0                  = cur.prep_kind;
          end
        end
      end
      ACT_FAIL_VISIBLE: begin
        if (shown_match && !cur.terminal_sent && (cur.phase == PH_PLAY)) begin
          nxt.phase         = PH_FAIL;
          nxt.terminal_sent = 1'b1;
          n_ev              = 2'd1;
          k0                = EV_FAILED;
          f0                = item.failure_code;
          c0                = cur.shown_kind;
        end
      end
      ACT_PROGRESS: begin
        if (prep_match) begin
          nxt.prep_fail_count = '0;
        end
      end
      ACT_WSTART: begin
        nxt.worker_on      = 1'b1;
        nxt.stop_requested = 1'b0;
      end
      ACT_WSTOP: begin
        if (cur.worker_on) begin
          nxt.stop_requested = 1'b1;
        end
      end
      ACT_WEXIT: begin
        nxt.worker_on      = 1'b0;
        nxt.stop_requested = 1'b0;
      end
      default: begin
      end
    endcase
    nxt.event_counter = cur.event_counter + {30'd0, n_ev};
  end

  assign retry = (nxt.phase == PH_PREP) && (nxt.prep_generation == item.generation) &&
                 (nxt.prep_ticket == item.ticket) && !nxt.terminal_sent;
  assign two   = n_ev == 2'd2;

  always_comb begin
    res0.event_kind       = k0;
    res0.event_failure    = f0;
    res0.event_generation = item.generation;
    res0.event_ticket     = item.ticket;
    res0.event_clip_kind  = c0;
    res0.cycles_done      = cd0;
    res0.sequence_number  = cur.event_counter + 32'd1;
    res0.phase_now        = nxt.phase;
    res0.retry_allowed    = retry;
    res0.worker_active    = nxt.worker_on;
    res0.stop_pending     = nxt.stop_requested;
    res0.last             = !two;
    if (n_ev == 2'd0) begin
      // status-only word
      res0.event_failure    = 4'd0;
      res0.event_generation = '0;
      res0.event_ticket     = '0;
      res0.event_clip_kind  = KIND_NONE;
      res0.cycles_done      = nxt.cycle_count[CycW-1:0];
      res0.sequence_number  = cur.event_counter;
    end

    res1                  = res0;
    res1.event_kind       = k1;
    res1.event_failure    = 4'd0;
    res1.cycles_done      = cd1;
    res1.sequence_number  = cur.event_counter + 32'd2;
    res1.last             = 1'b1;
  end

endmodule

// ===== verif/playback_lifecycle_tracker_test.sv =====
// Testbench for playback_lifecycle_tracker: drives lifecycle events on the input stream
// and checks each result word against a predictor of the phase tracking logic.
// Depends on plt_pkg and the tracker RTL only.
`timescale 1ns / 1ps

module playback_lifecycle_tracker_test;
  import plt_pkg::*;

  class lifecycle_scoreboard;
    logic [7:0]         fail_limit;
    phase_t             phase;
    logic [31:0]        prep_gen, prep_tk, shown_gen, shown_tk;
    logic signed [31:0] prep_kind, shown_kind;
    logic [7:0]         fail_count;
    logic [31:0]        loop_count, event_count;
    bit                 terminal_sent, running, stop_req;
    result_t            expected_words[$];
    result_t            fresh[$];
    int                 mismatches;

    function new();
      fail_limit    = '0;
      phase         = PH_IDLE;
      prep_gen      = '0;
      prep_tk       = '0;
      prep_kind     = KIND_NONE;
      shown_gen     = '0;
      shown_tk      = '0;
      shown_kind    = KIND_NONE;
      fail_count    = '0;
      loop_count    = '0;
      event_count   = '0;
      terminal_sent = 1'b0;
      running       = 1'b0;
      stop_req      = 1'b0;
      mismatches    = 0;
    endfunction

    function void log_event(input ev_kind_t kind, input logic [3:0] fcode,
                            input logic [31:0] g, input logic [31:0] t,
                            input logic signed [31:0] ck);
      result_t r;
      r = '0;
      event_count++;
      r.event_kind       = kind;
      r.event_failure    = fcode;
      r.event_generation = g;
      r.event_ticket     = t;
      r.event_clip_kind  = ck;
      r.cycles_done      = loop_count[15:0];
      r.sequence_number  = event_count;
      fresh.push_back(r);
    endfunction

    // Advance the tracker state for one accepted input word and queue its results.
    function void note_event(input item_t it);
      bit                 prep_match, shown_match, at_end, retry;
      logic signed [31:0] failed_kind;
      result_t            r;
      prep_match  = phase == PH_PREP && prep_gen == it.generation && prep_tk == it.ticket;
      shown_match = shown_gen == it.generation && shown_tk == it.ticket;
      fresh.delete();
      case (it.action)
        ACT_BEGIN_PREPARE: begin
          if (it.generation != 0) begin
            phase         = PH_PREP;
            prep_gen      = it.generation;
            prep_tk       = it.ticket;
            prep_kind     = it.clip_kind;
            fail_count    = '0;
            terminal_sent = 1'b0;
            log_event(EV_PREPARING, 4'd0, it.generation, it.ticket, it.clip_kind);
          end
        end
        ACT_COMMIT: begin
          if (prep_match && prep_kind == it.clip_kind && it.frame_total != 0) begin
            shown_gen  = it.generation;
            shown_tk   = it.ticket;
            shown_kind = it.clip_kind;
            prep_gen   = '0;
            prep_tk    = '0;
            prep_kind  = KIND_NONE;
            fail_count = '0;
            loop_count = '0;
            phase      = PH_PLAY;
            log_event(EV_COMMITTED, 4'd0, it.generation, it.ticket, it.clip_kind);
            // a one-frame clip finishes its first pass on commit
            if (it.frame_total == 1) begin
              if (it.looping) begin
                loop_count++;
                log_event(EV_CYCLE, 4'd0, it.generation, it.ticket, it.clip_kind);
              end else begin
                phase         = PH_DONE;
                terminal_sent = 1'b1;
                log_event(EV_COMPLETED, 4'd0, it.generation, it.ticket, it.clip_kind);
              end
            end
          end
        end
        ACT_FRAME: begin
          if (shown_match && it.frame_total != 0 && (phase == PH_PLAY || phase == PH_DONE)) begin
            at_end = it.frame_number == it.frame_total - 32'd1;
            if (it.looping && at_end) begin
              loop_count++;
              log_event(EV_CYCLE, 4'd0, it.generation, it.ticket, shown_kind);
            end else if (!it.looping && at_end && !terminal_sent) begin
              phase         = PH_DONE;
              terminal_sent = 1'b1;
              log_event(EV_COMPLETED, 4'd0, it.generation, it.ticket, shown_kind);
            end
          end
        end
        ACT_PREP_FAIL: begin
          if (prep_match && !terminal_sent) begin
            if (fail_count != 8'd255) fail_count++;
            if (fail_limit == 0 || fail_count >= fail_limit) begin
              failed_kind   = prep_kind;
              phase         = PH_FAIL;
              prep_gen      = '0;
              prep_tk       = '0;
              prep_kind     = KIND_NONE;
              terminal_sent = 1'b1;
              log_event(EV_FAILED, it.failure_code, it.generation, it.ticket, failed_kind);
            end
          end
        end
        ACT_FAIL_VISIBLE: begin
          if (shown_match && !terminal_sent && phase == PH_PLAY) begin
            phase         = PH_FAIL;
            terminal_sent = 1'b1;
            log_event(EV_FAILED, it.failure_code, it.generation, it.ticket, shown_kind);
          end
        end
        ACT_PROGRESS: begin
          if (prep_match) fail_count = '0;
        end
        ACT_WSTART: begin
          running  = 1'b1;
          stop_req = 1'b0;
        end
        ACT_WSTOP: begin
          if (running) stop_req = 1'b1;
        end
        ACT_WEXIT: begin
          running  = 1'b0;
          stop_req = 1'b0;
        end
        default: ;
      endcase

      if (fresh.size() == 0) begin
        r = '0;
        r.event_kind      = EV_NONE;
        r.event_clip_kind = KIND_NONE;
        r.cycles_done     = loop_count[15:0];
        r.sequence_number = event_count;
        fresh.push_back(r);
      end
      retry = phase == PH_PREP && prep_gen == it.generation && prep_tk == it.ticket &&
              !terminal_sent;
      foreach (fresh[k]) begin
        r = fresh[k];
        r.phase_now     = phase;
        r.retry_allowed = retry;
        r.worker_active = running;
        r.stop_pending  = stop_req;
        r.last          = k == fresh.size() - 1;
        expected_words.push_back(r);
      end
    endfunction

    function string show(input result_t r);
      return $sformatf({"kind=%0d fail=%0d gen=%h tk=%h ck=%h cyc=%0d seq=%0d ",
                        "ph=%0d retry=%b wk=%b stop=%b last=%b"},
                       r.event_kind, r.event_failure, r.event_generation, r.event_ticket,
                       r.event_clip_kind, r.cycles_done, r.sequence_number, r.phase_now,
                       r.retry_allowed, r.worker_active, r.stop_pending, r.last);
    endfunction

    function void check_word(input result_t got);
      result_t exp;
      bit      bad;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", show(got));
        return;
      end
      exp = expected_words.pop_front();
      bad = got.event_kind       !== exp.event_kind       ||
            got.event_failure    !== exp.event_failure    ||
            got.event_generation !== exp.event_generation ||
            got.event_ticket     !== exp.event_ticket     ||
            got.event_clip_kind  !== exp.event_clip_kind  ||
            got.cycles_done      !== exp.cycles_done      ||
            got.sequence_number  !== exp.sequence_number  ||
            got.phase_now        !== exp.phase_now        ||
            got.retry_allowed    !== exp.retry_allowed    ||
            got.worker_active    !== exp.worker_active    ||
            got.stop_pending     !== exp.stop_pending     ||
            got.last             !== exp.last;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected %s", show(exp));
          $display("                 actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  lifecycle_scoreboard book = new();
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [31:0] cur_total = 32'd1;
  logic        cur_loop = 1'b0;

  playback_lifecycle_tracker uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
  end

  // result word monitor
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.event_kind       = ev_kind_t'(m_axis_tuser);
      got.event_failure    = m_axis_tdata[3:0];
      got.event_generation = m_axis_tdata[35:4];
      got.event_ticket     = m_axis_tdata[67:36];
      got.event_clip_kind  = m_axis_tdata[99:68];
      got.cycles_done      = m_axis_tdata[115:100];
      got.sequence_number  = m_axis_tdata[147:116];
      got.phase_now        = phase_t'(m_axis_tdata[150:148]);
      got.retry_allowed    = m_axis_tdata[151];
      got.worker_active    = m_axis_tdata[152];
      got.stop_pending     = m_axis_tdata[153];
      got.last             = m_axis_tlast;
      book.check_word(got);
    end
  end

  function automatic bit coin(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic item_t make_item(input logic [3:0] act, input logic [31:0] g,
                                      input logic [31:0] t, input logic [31:0] ck,
                                      input logic [31:0] fnum, input logic [31:0] ftot,
                                      input logic lp, input logic [3:0] fcode);
    item_t it;
    it.action       = action_t'(act);
    it.generation   = g;
    it.ticket       = t;
    it.clip_kind    = ck;
    it.frame_number = fnum;
    it.frame_total  = ftot;
    it.looping      = lp;
    it.failure_code = fcode;
    return it;
  endfunction

  // Mostly well-formed events aimed at the tags the tracker currently holds.
  function automatic item_t random_event();
    item_t it;
    int    pick;
    it = make_item(4'($urandom_range(15)), $urandom, $urandom, $urandom, $urandom, $urandom,
                   1'($urandom_range(1)), 4'($urandom_range(15)));
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.action = ACT_BEGIN_PREPARE;
      if (coin(10)) it.generation = '0;
      case ($urandom_range(4))
        0: it.clip_kind = KIND_NONE;
        1: it.clip_kind = 32'h7fff_ffff;
        2: it.clip_kind = 32'h8000_0000;
        3: it.clip_kind = $urandom_range(7);
        default: ;
      endcase
    end else if (pick < 44) begin
      it.action = pick < 14 ? ACT_PROGRESS : pick < 30 ? ACT_PREP_FAIL : ACT_COMMIT;
      if (coin(85)) begin
        it.generation = book.prep_gen;
        it.ticket     = book.prep_tk;
      end
      if (it.action == ACT_COMMIT) begin
        if (coin(85)) it.clip_kind = book.prep_kind;
        case ($urandom_range(9))
          0: it.frame_total = '0;
          1, 2: it.frame_total = 32'd1;
          3: ;
          default: it.frame_total = $urandom_range(4, 1);
        endcase
        cur_total = it.frame_total;
        cur_loop  = it.looping;
      end
    end else if (pick < 79) begin
      it.action = pick < 74 ? ACT_FRAME : ACT_FAIL_VISIBLE;
      if (coin(90)) begin
        it.generation = book.shown_gen;
        it.ticket     = book.shown_tk;
      end
      if (coin(90)) begin
        it.frame_total = cur_total;
        it.looping     = cur_loop;
      end
      if (coin(60)) it.frame_number = it.frame_total - 32'd1;
      else if (it.frame_total != 0) it.frame_number = $urandom % it.frame_total;
    end else if (pick < 89) begin
      it.action = action_t'($urandom_range(ACT_WEXIT, ACT_WSTART));
    end else if (pick < 93) begin
      it.action = action_t'($urandom_range(15, 9));
    end
    // near misses on the tags
    if (pick < 79 && coin(5)) begin
      if (coin(50)) it.ticket ^= 32'd1 << $urandom_range(31);
      else it.generation ^= 32'd1 << $urandom_range(31);
    end
    return it;
  endfunction

  task automatic push_event(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.failure_code, it.looping, it.frame_total,
                      it.frame_number, it.clip_kind, it.ticket, it.generation};
    s_axis_tuser  <= it.action;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_event(it);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (book.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    book.fail_limit = value;
  endtask

  initial begin
    logic [7:0] plan [6];
    plan = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd200};
    send_idle_pct = 24;
    recv_idle_pct = 76;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed pass, failure limit still at its reset value
    push_event(make_item(4'd15, '1, '1, '1, '1, '1, 1'b1, 4'd15));
    push_event(make_item(ACT_WSTOP, 0, 0, 0, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_WSTART, 0, 0, 0, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_WSTOP, 0, 0, 0, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_WEXIT, 0, 0, 0, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_BEGIN_PREPARE, 0, 32'd7, 32'd3, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_BEGIN_PREPARE, '1, '1, 32'h8000_0000, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_PROGRESS, '1, '1, 0, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_PREP_FAIL, '1, '1, 0, 0, 0, 1'b0, 4'd15));
    push_event(make_item(ACT_BEGIN_PREPARE, 32'd1, 0, 32'h7fff_ffff, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_COMMIT, 32'd1, 0, 32'h7fff_ffff, 0, 0, 1'b1, 4'd0));
    push_event(make_item(ACT_COMMIT, 32'd1, 0, 32'h7fff_ffff, 0, 32'd1, 1'b1, 4'd0));
    push_event(make_item(ACT_FRAME, 32'd1, 0, 0, 0, 32'd1, 1'b1, 4'd0));
    push_event(make_item(ACT_FRAME, 32'd1, 0, 0, 32'hffff_fffe, '1, 1'b0, 4'd0));
    push_event(make_item(ACT_FRAME, 32'd1, 0, 0, 32'hffff_fffe, '1, 1'b0, 4'd0));
    push_event(make_item(ACT_BEGIN_PREPARE, 32'd2, 32'd5, KIND_NONE, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_COMMIT, 32'd2, 32'd5, KIND_NONE, 0, 32'd1, 1'b0, 4'd0));
    push_event(make_item(ACT_BEGIN_PREPARE, 32'd3, 32'd6, 0, 0, 0, 1'b0, 4'd0));
    push_event(make_item(ACT_PREP_FAIL, 32'd3, 32'd7, 0, 0, 0, 1'b0, 4'd2));
    push_event(make_item(ACT_COMMIT, 32'd3, 32'd6, 0, 0, 32'd3, 1'b0, 4'd0));
    push_event(make_item(ACT_FRAME, 32'd3, 32'd6, 0, 32'd1, 32'd3, 1'b0, 4'd0));
    push_event(make_item(ACT_FAIL_VISIBLE, 32'd3, 32'd6, 0, 0, 0, 1'b0, 4'd9));
    push_event(make_item(ACT_FAIL_VISIBLE, 32'd3, 32'd6, 0, 0, 0, 1'b0, 4'd9));

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p / 2)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_limit(plan[p]);
      // walk the failure count all the way up to the top limit
      if (plan[p] == 8'd255) begin
        push_event(make_item(ACT_BEGIN_PREPARE, $urandom | 32'd1, $urandom, $urandom,
                             0, 0, 1'b0, 4'd0));
        repeat (256)
          push_event(make_item(ACT_PREP_FAIL, book.prep_gen, book.prep_tk, 0, 0, 0,
                               1'b0, 4'($urandom_range(15))));
      end
      repeat (200) push_event(random_event());
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (book.mismatches == 0 && book.expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
